// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL of the escape-time iterator.
// No dependencies; every macro takes its clock and active-low reset explicitly.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/etfi_pkg.sv -----
// Package for the escape-time fractal iterator: sequencer types, register
// indexes and the microcode ROM. No dependencies.
`default_nettype none

package etfi_pkg;

	// Fixed field widths
	localparam int unsigned CoordW  = 32;
	localparam int unsigned RadiusW = 31;
	localparam int unsigned IterW   = 7;
	localparam int unsigned FracW   = 24;

	// Configuration register indexes (byte address = 4 * index)
	typedef enum logic [1:0] {
		REG_RADIUS = 2'd0,
		REG_MODE   = 2'd1,
		REG_C_RE   = 2'd2,
		REG_C_IM   = 2'd3
	} reg_idx_t;

	// Sequencer step addresses
	typedef enum logic [2:0] {
		STEP_WAIT = 3'd0,
		STEP_LIM  = 3'd1,
		STEP_SQR  = 3'd2,
		STEP_TEST = 3'd3,
		STEP_DONE = 3'd4
	} step_t;

	// Jump condition select
	typedef enum logic [1:0] {
		COND_ALWAYS   = 2'd0,
		COND_ACCEPT   = 2'd1,
		COND_STOP     = 2'd2,
		COND_OUT_FREE = 2'd3
	} cond_t;

	// One control word: datapath strobes plus branch targets
	typedef struct packed {
		logic  in_rdy;   // accept a request in this step
		logic  lim_ld;   // square the escape radius
		logic  mul_ld;   // form re^2, im^2, re*im
		logic  upd;      // escape test and z update
		logic  emit;     // write the result register
		cond_t cond;
		step_t tgt_true;
		step_t tgt_false;
	} ucode_t;

	// Microcode ROM
	function automatic ucode_t ucode_rd(input step_t step);
		ucode_t cw;
		cw = '{in_rdy: 1'b0, lim_ld: 1'b0, mul_ld: 1'b0, upd: 1'b0, emit: 1'b0,
			cond: COND_ALWAYS, tgt_true: STEP_WAIT, tgt_false: STEP_WAIT};
		case (step)
			STEP_WAIT: begin
				cw.in_rdy    = 1'b1;
				cw.cond      = COND_ACCEPT;
				cw.tgt_true  = STEP_LIM;
				cw.tgt_false = STEP_WAIT;
			end
			STEP_LIM: begin
				cw.lim_ld    = 1'b1;
				cw.tgt_true  = STEP_SQR;
				cw.tgt_false = STEP_SQR;
			end
			STEP_SQR: begin
				cw.mul_ld    = 1'b1;
				cw.tgt_true  = STEP_TEST;
				cw.tgt_false = STEP_TEST;
			end
			STEP_TEST: begin
				cw.upd       = 1'b1;
				cw.cond      = COND_STOP;
				cw.tgt_true  = STEP_DONE;
				cw.tgt_false = STEP_SQR;
			end
			STEP_DONE: begin
				cw.emit      = 1'b1;
				cw.cond      = COND_OUT_FREE;
				cw.tgt_true  = STEP_WAIT;
				cw.tgt_false = STEP_DONE;
			end
			default: begin
				cw.tgt_true  = STEP_WAIT;
				cw.tgt_false = STEP_WAIT;
			end
		endcase
		return cw;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/escape_time_fractal_iterator_top.sv -----
// Escape-time iterator (z = z*z + c), microcoded; uses etfi_pkg, assert_macros.svh.
// The block takes no new request until the result of the last one is written;
// the result waits in the done step while an earlier result is still stalled.
// Each iteration runs the two-step loop: three parallel multipliers,
// then escape compare and z update. Asynchronous active-low reset restores
// the register defaults and returns the sequencer to its wait step.
`default_nettype none
`include "assert_macros.svh"

module escape_time_fractal_iterator_top #(
	parameter int unsigned MAX_ITER = 80
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] point_re,
	input  wire logic [31:0] point_im,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [6:0]       iter_count,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int unsigned CntMin = $clog2(MAX_ITER + 1);
	localparam int unsigned CntW   = (CntMin > etfi_pkg::IterW) ? CntMin : etfi_pkg::IterW;
	localparam int unsigned CW     = etfi_pkg::CoordW;
	localparam int unsigned PW     = 2 * CW;

	// Configuration registers
	logic [etfi_pkg::RadiusW-1:0] radius_q;
	logic                         mode_q;
	logic [CW-1:0]                jc_re_q;
	logic [CW-1:0]                jc_im_q;

	// Sequencer state
	etfi_pkg::step_t  step_q;
	etfi_pkg::ucode_t cw;
	logic [CntW-1:0]  n_q;
	logic             out_valid_q;
	logic [6:0]       iter_q;

	// Datapath registers
	logic signed [CW-1:0] re_q, im_q, cre_q, cim_q;
	logic signed [PW-1:0] rr_q, ii_q, ri_q;
	logic [2*etfi_pkg::RadiusW-1:0] lim_q;

	// Datapath wires
	logic signed [CW-1:0] mul_a;
	logic signed [PW-1:0] prod0, prod1, prod2;
	logic [PW-1:0]        mag;
	logic                 escape;
	logic                 last;
	logic signed [PW-1:0] diff;
	logic signed [CW+9:0] nre, nim;
	logic                 cond_hit;
	logic                 accept;
	etfi_pkg::reg_idx_t   widx;

	// Configuration write and readback
	assign pready = 1'b1;
	assign widx   = etfi_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= etfi_pkg::RadiusW'(33554432);
			mode_q   <= 1'b0;
			jc_re_q  <= '0;
			jc_im_q  <= '0;
		end else if (psel && penable && pwrite) begin
			case (widx)
				etfi_pkg::REG_RADIUS: radius_q <= pwdata[etfi_pkg::RadiusW-1:0];
				etfi_pkg::REG_MODE:   mode_q   <= pwdata[0];
				etfi_pkg::REG_C_RE:   jc_re_q  <= pwdata;
				etfi_pkg::REG_C_IM:   jc_im_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			etfi_pkg::REG_RADIUS: prdata = {1'b0, radius_q};
			etfi_pkg::REG_MODE:   prdata = {31'd0, mode_q};
			etfi_pkg::REG_C_RE:   prdata = jc_re_q;
			etfi_pkg::REG_C_IM:   prdata = jc_im_q;
			default:              prdata = '0;
		endcase
	end

	// Microcode fetch and handshake
	assign cw        = etfi_pkg::ucode_rd(step_q);
	assign in_stall  = !cw.in_rdy;
	assign accept    = in_valid && cw.in_rdy;
	assign out_valid = out_valid_q;
	assign iter_count = iter_q;

	// Multipliers: port 0 is shared between radius squaring and re^2
	assign mul_a = cw.lim_ld ? $signed({1'b0, radius_q}) : re_q;
	assign prod0 = mul_a * mul_a;
	assign prod1 = im_q * im_q;
	assign prod2 = re_q * im_q;

	// Escape test in Q16.48
	assign mag    = rr_q + ii_q;
	assign escape = mag > {2'b00, lim_q};
	assign last   = (n_q == CntW'(MAX_ITER - 1));

	// z update: floor shifts are part-selects of the signed products
	assign diff = rr_q - ii_q;
	assign nre  = {{2{diff[PW-1]}}, diff[PW-1:etfi_pkg::FracW]}
		+ {{10{cre_q[CW-1]}}, cre_q};
	assign nim  = {ri_q[PW-1], ri_q[PW-1:etfi_pkg::FracW-1]}
		+ {{10{cim_q[CW-1]}}, cim_q};

	function automatic logic [CW-1:0] sat32(input logic signed [CW+9:0] x);
		logic [CW-1:0] res;
		if (x > $signed({{10{1'b0}}, 1'b0, {(CW-1){1'b1}}})) begin
			res = {1'b0, {(CW-1){1'b1}}};
		end else if (x < $signed({{10{1'b1}}, 1'b1, {(CW-1){1'b0}}})) begin
			res = {1'b1, {(CW-1){1'b0}}};
		end else begin
			res = x[CW-1:0];
		end
		return res;
	endfunction

	// Branch condition
	always_comb begin
		case (cw.cond)
			etfi_pkg::COND_ALWAYS:   cond_hit = 1'b1;
			etfi_pkg::COND_ACCEPT:   cond_hit = in_valid;
			etfi_pkg::COND_STOP:     cond_hit = escape || last;
			etfi_pkg::COND_OUT_FREE: cond_hit = !out_valid_q || !out_stall;
			default:                 cond_hit = 1'b1;
		endcase
	end

	// Sequencer, counter and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= etfi_pkg::STEP_WAIT;
			n_q         <= '0;
			out_valid_q <= 1'b0;
			iter_q      <= '0;
		end else begin
			step_q <= cond_hit ? cw.tgt_true : cw.tgt_false;
			if (accept) begin
				n_q <= '0;
			end else if (cw.upd && !escape) begin
				n_q <= n_q + CntW'(1);
			end
			// a new result replaces one that leaves in the same cycle
			if (cw.emit && cond_hit) begin
				out_valid_q <= 1'b1;
				iter_q      <= n_q[etfi_pkg::IterW-1:0];
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			re_q  <= point_re;
			im_q  <= point_im;
			cre_q <= mode_q ? jc_re_q : point_re;
			cim_q <= mode_q ? jc_im_q : point_im;
		end else if (cw.upd && !escape) begin
			re_q <= sat32(nre);
			im_q <= sat32(nim);
		end
		if (cw.lim_ld) begin
			lim_q <= prod0[2*etfi_pkg::RadiusW-1:0];
		end
		if (cw.mul_ld) begin
			rr_q <= prod0;
			ii_q <= prod1;
			ri_q <= prod2;
		end
	end

	// Checks
	`ASSERT_IMPLIES(a_cnt_bound, clk, arst_n, 1'b1, n_q <= CntW'(MAX_ITER))
	`ASSERT_NEXT(a_accept_to_lim, clk, arst_n, in_valid && !in_stall,
		step_q == etfi_pkg::STEP_LIM)
	`ASSERT_IMPLIES(a_emit_from_done, clk, arst_n, $rose(out_valid_q),
		$past(step_q) == etfi_pkg::STEP_DONE)
	`ASSERT_IMPLIES(a_lim_held, clk, arst_n, step_q == etfi_pkg::STEP_TEST, $stable(lim_q))

endmodule

`default_nettype wire

// ----- tb/escape_time_fractal_iterator_top_test.sv -----
// Self-checking test of the escape-time fractal iterator: a directed table of points and
// register settings, then random phases, checked against table counts or a local model.
// Depends on etfi_pkg and the escape_time_fractal_iterator_top RTL.
`default_nettype none

module escape_time_fractal_iterator_top_test;

	localparam int unsigned MAX_ITER  = 80;
	localparam int          CALC      = -1;       // row expectation comes from the predictor
	localparam int          RAND_PH   = 10;
	localparam int          PH_POINTS = 193;
	localparam int          HOLD_LEN  = 600;

	// Q8.24 constants
	localparam logic [31:0] R2    = 32'h0200_0000;
	localparam logic [31:0] SMAX  = 32'h7FFF_FFFF;
	localparam logic [31:0] SMIN  = 32'h8000_0000;
	localparam logic [31:0] ONE   = 32'h0100_0000;
	localparam logic [31:0] TWO   = 32'h0200_0000;
	localparam logic [31:0] MONE  = 32'hFF00_0000;
	localparam logic [31:0] MTWO  = 32'hFE00_0000;

	typedef struct packed {
		logic [31:0] rad;
		logic [31:0] mode;
		logic [31:0] c_re;
		logic [31:0] c_im;
		logic [31:0] re;
		logic [31:0] im;
		int          want;
	} point_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] point_re;
	logic [31:0] point_im;
	logic        out_valid;
	logic        out_stall;
	logic [6:0]  iter_count;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// shadow copy of the register file
	logic [30:0]        cfg_radius;
	logic               cfg_julia;
	logic signed [31:0] cfg_c_re;
	logic signed [31:0] cfg_c_im;
	logic [31:0]        last_words [4];

	logic [6:0] count_due_q [$];
	int         err_cnt = 0;
	int         hold_len = 0;
	bit         no_idle = 1'b0;

	point_row_t point_tab [24] = '{
		'{R2,   0, 0, 0, 0,    0,    80},
		'{R2,   0, 0, 0, SMAX, SMAX, 0},
		'{R2,   0, 0, 0, SMIN, SMIN, 0},
		'{R2,   0, 0, 0, TWO,  0,    1},
		'{R2,   0, 0, 0, MTWO, 0,    80},
		'{R2,   0, 0, 0, MONE, 0,    80},
		'{R2,   0, 0, 0, 0,    ONE,  80},
		'{R2,   0, 0, 0, 32'h0040_0000, 0, CALC},
		'{R2,   0, 0, 0, 32'hFF40_0000, 32'h0010_0000, CALC},
		'{R2,   0, 0, 0, 32'h0000_0001, 32'hFFFF_FFFF, CALC},
		// zero radius: only the origin survives
		'{0,    0, 0, 0, 0,    0,    80},
		'{0,    0, 0, 0, 1,    0,    0},
		'{0,    0, 0, 0, 0,    32'hFFFF_FFFF, 0},
		// widest radius: parts saturate
		'{SMAX, 0, 0, 0, SMAX, 0,    CALC},
		'{SMAX, 0, 0, 0, SMIN, 0,    0},
		'{SMAX, 0, 0, 0, 32'h1000_0000, 32'h1000_0000, CALC},
		'{SMAX, 0, 0, 0, 0,    SMAX, CALC},
		// Julia constant
		'{R2,   1, 0, 0, 0,    0,    80},
		'{R2,   1, 0, 0, ONE,  0,    80},
		'{R2,   1, 32'hFF33_3333, 32'h0027_EF9D, 32'h0019_999A, 32'h0019_999A, CALC},
		'{SMAX, 1, SMIN, SMAX, 0, 0, CALC},
		'{SMAX, 1, SMAX, SMIN, SMAX, SMIN, 0},
		// upper register bits ignored: radius 2.0, Mandelbrot
		'{32'h8200_0000, 32'hFFFF_FFFE, MTWO, 0, TWO, 0, 1},
		'{R2,   1, MTWO, 0, TWO,  0,    80}
	};

	escape_time_fractal_iterator_top #(.MAX_ITER(MAX_ITER)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.point_re   (point_re),
		.point_im   (point_im),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.iter_count (iter_count),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #2 clk = ~clk;

	// clamp to the signed 32-bit range
	function automatic longint clamp32(input longint v);
		if (v > longint'(32'sh7FFF_FFFF))
			return longint'(32'sh7FFF_FFFF);
		if (v < -longint'(32'sh7FFF_FFFF) - 64'sd1)
			return -longint'(32'sh7FFF_FFFF) - 64'sd1;
		return v;
	endfunction

	// Steps taken by z = z*z + c before |z|^2 passes radius^2 or the limit is hit
	function automatic logic [6:0] escape_count(input logic signed [31:0] p_re,
			input logic signed [31:0] p_im);
		longint      zr, zi, cr, ci, rr, ii;
		logic [63:0] lim, mag;
		int unsigned n;
		bit          gone;
		zr = p_re;
		zi = p_im;
		cr = zr;
		ci = zi;
		if (cfg_julia) begin
			cr = cfg_c_re;
			ci = cfg_c_im;
		end
		lim = {33'd0, cfg_radius} * {33'd0, cfg_radius};
		n = 0;
		gone = 1'b0;
		while (n < MAX_ITER && !gone) begin
			rr = zr * zr;
			ii = zi * zi;
			mag = $unsigned(rr) + $unsigned(ii);
			if (mag > lim) begin
				gone = 1'b1;
			end else begin
				zi = clamp32(((zr * zi) >>> (etfi_pkg::FracW - 1)) + ci);
				zr = clamp32(((rr - ii) >>> etfi_pkg::FracW) + cr);
				n++;
			end
		end
		return n[6:0];
	endfunction

	// APB write: setup then access phase
	task automatic write_reg(input etfi_pkg::reg_idx_t idx, input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			etfi_pkg::REG_RADIUS: cfg_radius = data[30:0];
			etfi_pkg::REG_MODE:   cfg_julia  = data[0];
			etfi_pkg::REG_C_RE:   cfg_c_re   = data;
			etfi_pkg::REG_C_IM:   cfg_c_im   = data;
			default:    ;
		endcase
	endtask

	// Drain all pending requests, then load all four registers
	task automatic program_regs(input logic [31:0] rad, mode, c_re, c_im);
		@(negedge clk);
		in_valid <= 1'b0;
		while (count_due_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		write_reg(etfi_pkg::REG_RADIUS, rad);
		write_reg(etfi_pkg::REG_MODE, mode);
		write_reg(etfi_pkg::REG_C_RE, c_re);
		write_reg(etfi_pkg::REG_C_IM, c_im);
		last_words = '{rad, mode, c_re, c_im};
	endtask

	// Offer one point; valid stays high after acceptance until the next call
	task automatic send_point(input logic [31:0] re, im, input int want);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 19);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		point_re <= re;
		point_im <= im;
		do @(posedge clk); while (in_stall);
		if (want == CALC)
			count_due_q.push_back(escape_count(re, im));
		else
			count_due_q.push_back(want[6:0]);
	endtask

	// Random point: mostly the interesting window, some near the origin, some full range
	function automatic logic [31:0] pick_coord();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return 32'($urandom_range(0, 83886080) - 32'd41943040);
		if (sel < 8)
			return 32'($urandom_range(0, 16777216) - 32'd8388608);
		return $urandom;
	endfunction

	// Request side and phase sequencing
	initial begin
		logic [31:0] rad, mode, c_re, c_im;
		int          ph;
		int          i;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		point_re = '0;
		point_im = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		cfg_radius = R2[30:0];
		cfg_julia  = 1'b0;
		cfg_c_re   = '0;
		cfg_c_im   = '0;
		last_words = '{R2, 32'd0, 32'd0, 32'd0};
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// directed table; registers reloaded whenever a row changes them
		foreach (point_tab[k]) begin
			if ({point_tab[k].rad, point_tab[k].mode, point_tab[k].c_re, point_tab[k].c_im} !=
					{last_words[0], last_words[1], last_words[2], last_words[3]})
				program_regs(point_tab[k].rad, point_tab[k].mode, point_tab[k].c_re,
					point_tab[k].c_im);
			send_point(point_tab[k].re, point_tab[k].im, point_tab[k].want);
		end

		// random phases across register settings
		for (ph = 0; ph < RAND_PH; ph++) begin
			mode = $urandom;
			c_re = pick_coord();
			c_im = pick_coord();
			case (ph % 5)
				0: begin
					rad  = R2 | ($urandom_range(0, 1) << 31);
					mode = mode & ~32'd1;
				end
				1: begin
					rad  = R2;
					mode = mode | 32'd1;
					c_re = 32'($urandom_range(0, 33554432) - 32'd16777216);
					c_im = 32'($urandom_range(0, 33554432) - 32'd16777216);
				end
				2: rad = SMAX | ($urandom_range(0, 1) << 31);
				3: rad = ($urandom_range(0, 1) != 0) ? 32'd0 : $urandom_range(0, 32'h0010_0000);
				default: rad = $urandom;
			endcase
			program_regs(rad, mode, c_re, c_im);
			no_idle = (ph == 3 || ph == 6 || ph == 8);
			// long receiver hold-off while requests keep coming
			if (ph == 6)
				hold_len = HOLD_LEN;
			for (i = 0; i < PH_POINTS; i++)
				send_point(pick_coord(), pick_coord(), CALC);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (count_due_q.size() != 0) @(posedge clk);
		repeat (2 * MAX_ITER + 8) @(posedge clk);
		if (err_cnt == 0)
			$display("escape_time_fractal_iterator_top_test passed");
		else
			$display("escape_time_fractal_iterator_top_test failed");
		$finish;
	end

	// Result side: stall for hold_len or a random gap (none with no_idle), then check each result
	initial begin
		int         gap;
		logic [6:0] want;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				gap = hold_len;
				hold_len = 0;
			end else begin
				gap = no_idle ? 0 : $urandom_range(0, 19);
			end
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			if (count_due_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, got iter_count %0d",
					$time, iter_count);
				err_cnt++;
			end else begin
				want = count_due_q.pop_front();
				if (iter_count !== want) begin
					$display("%0t: iter_count mismatch, expected %0d, got %0d",
						$time, want, iter_count);
					err_cnt++;
				end
			end
		end
	end

	// Watchdog
	initial begin
		#8000000;
		$display("escape_time_fractal_iterator_top_test failed");
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/etfi_pkg.sv
rtl/escape_time_fractal_iterator_top.sv
tb/escape_time_fractal_iterator_top_test.sv
